### hdl/repeated_block_freq_offset_estimator_assert.svh
// Assertion macros for the frequency offset estimator
`ifndef REPEATED_BLOCK_FREQ_OFFSET_ESTIMATOR_ASSERT_SVH
`define REPEATED_BLOCK_FREQ_OFFSET_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define RBFO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RBFO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBFO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RBFO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/rbfo_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbfo_pkg
// Types and constants shared by the frequency offset estimator.
// ---------------------------------------------------------------------------
package rbfo_pkg;
    localparam int ANGLE_BITS = 20;
    localparam int ACC_BITS   = 52;
    localparam int MAX_LAGS   = 5;

    localparam logic [2:0] REG_NUM_PARTS = 3'd0;
    localparam logic [2:0] REG_SEG_LEN   = 3'd1;
    localparam logic [2:0] REG_BLOCK_LEN = 3'd2;
    localparam logic [2:0] REG_WEIGHT1   = 3'd3;
    localparam logic [2:0] REG_WEIGHT2   = 3'd4;
    localparam logic [2:0] REG_WEIGHT3   = 3'd5;
    localparam logic [2:0] REG_WEIGHT4   = 3'd6;

    typedef enum logic [2:0] {
        S_LOAD, S_MAC, S_MAC_END, S_CORDIC, S_PHASE, S_SCALE, S_OUT
    } t_state;

    typedef struct packed {
        logic mac_start;   // clear accumulators, set index to lag times segment length
        logic mac_step;    // one product term
        logic cord_start;  // load CORDIC with accumulated sum
        logic cord_step;
        logic phase_add;   // accumulate weighted difference
        logic sum_clear;
        logic scale;
        logic [2:0] lag;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
        logic cord_done;
    } t_stat;

    function automatic logic [ANGLE_BITS-1:0] atan_val(input logic [4:0] i);
        case (i)
            5'd0: atan_val = 20'd131072;  5'd1: atan_val = 20'd77376;
            5'd2: atan_val = 20'd40884;   5'd3: atan_val = 20'd20753;
            5'd4: atan_val = 20'd10417;   5'd5: atan_val = 20'd5213;
            5'd6: atan_val = 20'd2607;    5'd7: atan_val = 20'd1304;
            5'd8: atan_val = 20'd652;     5'd9: atan_val = 20'd326;
            5'd10: atan_val = 20'd163;    5'd11: atan_val = 20'd81;
            5'd12: atan_val = 20'd41;     5'd13: atan_val = 20'd20;
            5'd14: atan_val = 20'd10;     5'd15: atan_val = 20'd5;
            5'd16: atan_val = 20'd3;      5'd17: atan_val = 20'd1;
            5'd18: atan_val = 20'd1;
            default: atan_val = 20'd0;
        endcase
    endfunction
endpackage

### hdl/rbfo_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbfo_stream_if
// Valid/ready channel carrying a payload of configurable width.
// ---------------------------------------------------------------------------
interface rbfo_stream_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rbfo_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbfo_ctrl
// Sequencer: load, per-lag correlation and CORDIC, phase sum, output.
// ---------------------------------------------------------------------------
`include "repeated_block_freq_offset_estimator_assert.svh"
module rbfo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_last,
    input  logic [2:0]      i_half,
    input  logic            i_out_fire,
    input  rbfo_pkg::t_stat i_stat,
    output rbfo_pkg::t_cmd  o_cmd,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    import rbfo_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_lag, n_lag;

    // next state; every lag passes through the phase step so the
    // previous angle is always taken from the lag just before
    always_comb begin
        n_state = r_state;
        n_lag   = r_lag;
        case (r_state)
            S_LOAD: if (i_in_fire && i_last) begin
                n_state = S_MAC;
                n_lag   = 3'd0;
            end
            S_MAC: n_state = S_MAC_END;
            S_MAC_END: if (i_stat.mac_done) n_state = S_CORDIC;
            S_CORDIC: if (i_stat.cord_done) n_state = S_PHASE;
            S_PHASE: begin
                if (r_lag == i_half) begin
                    n_state = S_SCALE;
                end else begin
                    n_state = S_MAC;
                    n_lag   = r_lag + 3'd1;
                end
            end
            S_SCALE: n_state = S_OUT;
            S_OUT: if (i_out_fire) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.lag        = r_lag;
        o_cmd.mac_start  = (r_state == S_MAC);
        o_cmd.mac_step   = (r_state == S_MAC_END) && !i_stat.mac_done;
        o_cmd.cord_start = (r_state == S_MAC_END) && i_stat.mac_done;
        o_cmd.cord_step  = (r_state == S_CORDIC) && !i_stat.cord_done;
        o_cmd.phase_add  = (r_state == S_PHASE);
        o_cmd.sum_clear  = (r_state == S_LOAD) && i_in_fire && i_last;
        o_cmd.scale      = (r_state == S_SCALE);
        o_in_ready       = (r_state == S_LOAD);
        o_out_valid      = (r_state == S_OUT);
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_lag   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_lag   <= n_lag;
        end
    end

    `RBFO_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `RBFO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_fire, o_out_valid)
    `RBFO_ASSERT_IMP(a_lag_range, i_clk, i_rst_n, r_state == S_PHASE, r_lag <= i_half)
endmodule

### hdl/rbfo_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rbfo_datapath
// Sample memory, complex MAC, CORDIC vectoring unit and phase accumulator.
// ---------------------------------------------------------------------------
module rbfo_datapath #(
    parameter int MAX_BLOCK    = 256,
    parameter int MAX_PARTS    = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rbfo_pkg::t_cmd         i_cmd,
    input  logic                   i_in_fire,
    input  logic [SAMPLE_BITS-1:0] i_re,
    input  logic [SAMPLE_BITS-1:0] i_im,
    input  logic [3:0]             i_num_parts,
    input  logic [7:0]             i_seg_len,
    input  logic [8:0]             i_block_len,
    input  logic [63:0]            i_weights,
    output logic                   o_last,
    output logic [2:0]             o_half,
    output rbfo_pkg::t_stat        o_stat,
    output logic [20:0]            o_freq
);
    import rbfo_pkg::*;

    localparam int AW  = $clog2(MAX_BLOCK);
    localparam int CW  = AW + 1;
    localparam int PW  = 2 * SAMPLE_BITS + 1;
    localparam int AB  = 2 * SAMPLE_BITS + 2 + CW;
    localparam int XB  = AB + 2;
    localparam int SW  = $clog2(CORDIC_STEPS + 1);
    localparam int MP  = (MAX_PARTS / 2) * 2;
    localparam int LOG_MP = $clog2(MP + 1);
    localparam int PSW = 40;

    // effective block length and part count
    logic [CW-1:0] w_len;
    always_comb begin
        if (i_block_len < 9'd2) w_len = CW'(1);
        else if ({23'd0, i_block_len} > MAX_BLOCK) w_len = CW'(MAX_BLOCK);
        else w_len = CW'(i_block_len);
    end
    logic [3:0] w_parts;
    always_comb begin
        w_parts = {i_num_parts[3:1], 1'b0};
        if ({28'd0, w_parts} > MP) w_parts = 4'(MP);
    end
    assign o_half = w_parts[3:1];

    // load counter
    logic [CW:0] r_cnt;
    assign o_last = ({1'b0, r_cnt} + 1) >= {1'b0, w_len};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (i_in_fire) r_cnt <= o_last ? '0 : r_cnt + 1'b1;
    end

    // sample memory, two read ports
    logic [2*SAMPLE_BITS-1:0] r_mem [MAX_BLOCK];
    logic [2*SAMPLE_BITS-1:0] r_rd_k, r_rd_j;
    logic [CW-1:0]            r_k;
    logic [CW-1:0]            w_shift;
    logic [CW-1:0]            w_j;
    logic                     r_k_run, r_p_vld, r_prod_vld;
    assign w_shift = CW'({8'd0, i_cmd.lag} * {3'd0, i_seg_len});
    assign w_j     = r_k - w_shift;
    always_ff @(posedge i_clk) begin
        if (i_in_fire && r_cnt < MAX_BLOCK) r_mem[r_cnt[AW-1:0]] <= {i_re, i_im};
        r_rd_k <= r_mem[r_k[AW-1:0]];
        r_rd_j <= r_mem[w_j[AW-1:0]];
    end

    // index walk
    logic [11:0] w_shift_full;
    assign w_shift_full = {6'd0, i_cmd.lag} * {4'd0, i_seg_len};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_run <= 1'b0; r_p_vld <= 1'b0; r_prod_vld <= 1'b0;
        end else begin
            r_p_vld    <= r_k_run && i_cmd.mac_step;
            r_prod_vld <= r_p_vld;
            if (i_cmd.mac_start) begin
                r_k     <= w_shift;
                r_k_run <= {3'd0, w_shift_full} < {3'd0, w_len[CW-1:0]} + 15'd0;
            end else if (i_cmd.mac_step && r_k_run) begin
                r_k     <= r_k + 1'b1;
                r_k_run <= (r_k + 1'b1) < w_len;
            end
        end
    end

    // products, registered
    logic signed [SAMPLE_BITS-1:0] w_kr, w_ki, w_jr, w_ji;
    assign w_kr = r_rd_k[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_ki = r_rd_k[SAMPLE_BITS-1:0];
    assign w_jr = r_rd_j[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_ji = r_rd_j[SAMPLE_BITS-1:0];
    logic signed [2*SAMPLE_BITS-1:0] r_p1, r_p2, r_p3, r_p4;
    always_ff @(posedge i_clk) begin
        r_p1 <= w_kr * w_jr;
        r_p2 <= w_ki * w_ji;
        r_p3 <= w_ki * w_jr;
        r_p4 <= w_kr * w_ji;
    end

    // accumulate
    logic signed [AB-1:0] r_acc_re, r_acc_im;
    logic                 w_mac_done, w_cord_done;
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_start) begin
            r_acc_re <= '0; r_acc_im <= '0;
        end else if (r_prod_vld) begin
            r_acc_re <= r_acc_re + AB'(PW'(r_p1) + PW'(r_p2));
            r_acc_im <= r_acc_im + AB'(PW'(r_p3) - PW'(r_p4));
        end
    end
    assign w_mac_done = !r_k_run && !r_p_vld && !r_prod_vld && !i_cmd.mac_start;

    // CORDIC vectoring, one step per cycle
    logic signed [XB-1:0] r_x, r_y;
    logic [ANGLE_BITS-1:0] r_z;
    logic [SW-1:0]         r_step;
    logic signed [XB-1:0]  w_xs, w_ys;
    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;
    assign w_cord_done = (r_step == SW'(CORDIC_STEPS));
    assign o_stat = {w_mac_done, w_cord_done};
    logic [ANGLE_BITS-1:0] r_ang_prev;
    always_ff @(posedge i_clk) begin
        if (i_cmd.cord_start) begin
            r_step <= '0;
            if (r_acc_re == 0 && r_acc_im == 0) begin
                r_x <= '0; r_y <= '0; r_z <= '0;
                r_step <= SW'(CORDIC_STEPS);
            end else if (r_acc_re < 0) begin
                r_x <= -XB'(r_acc_re); r_y <= -XB'(r_acc_im);
                r_z <= ANGLE_BITS'(1) << (ANGLE_BITS - 1);
            end else begin
                r_x <= XB'(r_acc_re); r_y <= XB'(r_acc_im); r_z <= '0;
            end
        end else if (i_cmd.cord_step) begin
            r_step <= r_step + 1'b1;
            if (!r_y[XB-1]) begin
                r_x <= r_x + w_ys; r_y <= r_y - w_xs;
                r_z <= r_z + atan_val(5'(r_step));
            end else begin
                r_x <= r_x - w_ys; r_y <= r_y + w_xs;
                r_z <= r_z - atan_val(5'(r_step));
            end
        end
        if (i_cmd.phase_add) r_ang_prev <= r_z;
    end

    // weighted phase sum
    logic signed [ANGLE_BITS-1:0] w_diff;
    logic [15:0]                  w_wt;
    logic signed [PSW-1:0]        r_sum;
    logic [1:0]                   w_widx;
    assign w_diff = r_z - r_ang_prev;
    assign w_widx = 2'(i_cmd.lag - 3'd1);
    assign w_wt   = i_weights[16*w_widx +: 16];
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clear) r_sum <= '0;
        else if (i_cmd.phase_add && i_cmd.lag != 3'd0)
            r_sum <= r_sum + PSW'($signed({1'b0, w_wt}) * w_diff);
    end

    // scale and saturate
    logic signed [PSW+LOG_MP:0] w_v;
    logic signed [PSW+LOG_MP:0] w_q;
    assign w_v = $signed({1'b0, w_parts}) * r_sum + (PSW+LOG_MP+1)'(1 << 18);
    assign w_q = w_v >>> 19;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            if (w_q > 1048575) o_freq <= 21'h0FFFFF;
            else if (w_q < -1048576) o_freq <= 21'h100000;
            else o_freq <= w_q[20:0];
        end
    end
endmodule

### hdl/repeated_block_freq_offset_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repeated_block_freq_offset_estimator
// Carrier frequency offset from a block of repeated parts.
// ---------------------------------------------------------------------------
// channel   dir  payload
// s_in      in   {sample_re, sample_im}
// m_out     out  freq_offset
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
// Samples load one per cycle. The last sample starts L/2+1 lag passes on
// one complex MAC (no products when the lag reaches past the block), then
// the CORDIC unit (no rotation steps for a zero sum) and one phase step
// per lag; a scale step and the output follow.
// No input is taken from block end until the result is accepted.
// Reset is synchronous, active low; the sample memory is not cleared.
module repeated_block_freq_offset_estimator #(
    parameter int MAX_BLOCK    = 256,
    parameter int MAX_PARTS    = 8,
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbfo_stream_if.sink   s_in,
    rbfo_stream_if.source m_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import rbfo_pkg::*;

    logic [3:0]  r_num_parts;
    logic [7:0]  r_seg_len;
    logic [8:0]  r_block_len;
    logic [63:0] r_weights;
    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_parts <= 4'd4; r_seg_len <= 8'd64; r_block_len <= 9'd256;
            r_weights <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NUM_PARTS: r_num_parts <= i_cfg_data[3:0];
                REG_SEG_LEN:   r_seg_len   <= i_cfg_data[7:0];
                REG_BLOCK_LEN: r_block_len <= i_cfg_data[8:0];
                REG_WEIGHT1:   r_weights[15:0]  <= i_cfg_data;
                REG_WEIGHT2:   r_weights[31:16] <= i_cfg_data;
                REG_WEIGHT3:   r_weights[47:32] <= i_cfg_data;
                REG_WEIGHT4:   r_weights[63:48] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_last, w_in_fire, w_out_fire;
    logic [2:0] w_half;
    assign w_in_fire  = s_in.valid && s_in.ready;
    assign w_out_fire = m_out.valid && m_out.ready;

    rbfo_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_fire(w_in_fire), .i_last(w_last), .i_half(w_half),
        .i_out_fire(w_out_fire), .i_stat(w_stat), .o_cmd(w_cmd),
        .o_in_ready(s_in.ready), .o_out_valid(m_out.valid)
    );

    rbfo_datapath #(
        .MAX_BLOCK(MAX_BLOCK), .MAX_PARTS(MAX_PARTS),
        .SAMPLE_BITS(SAMPLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
    ) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_in_fire(w_in_fire),
        .i_re(s_in.data[2*SAMPLE_BITS-1:SAMPLE_BITS]), .i_im(s_in.data[SAMPLE_BITS-1:0]),
        .i_num_parts(r_num_parts), .i_seg_len(r_seg_len), .i_block_len(r_block_len),
        .i_weights(r_weights), .o_last(w_last), .o_half(w_half), .o_stat(w_stat),
        .o_freq(m_out.data)
    );
endmodule
